FILE: sv/mgv_pkg.sv
// ----------------------------------------------------------------------------
// mgv_pkg: shared types and constants of the grid velocity update
// quotient width, divider depth, register indexes and the sideband struct
// ----------------------------------------------------------------------------
package mgv_pkg;

  // momentum magnitude, up to 2^31
  localparam int unsigned MagW      = 32;
  // mass and divider remainder
  localparam int unsigned MassW     = 31;
  // quotient bits kept; anything at or above 2^QuoW saturates anyway
  localparam int unsigned QuoW      = 34;
  localparam int unsigned FracW     = 16;
  // one quotient bit per divider stage
  localparam int unsigned DivStages = QuoW;
  // magnitude bits below this shift feed the divider, the rest form the starting remainder
  localparam int unsigned OvfShift  = QuoW - FracW;
  localparam int unsigned Lanes     = 3;

  typedef enum logic [1:0] {
    CFG_GRID_RES       = 2'd0,
    CFG_BOUNDARY_WIDTH = 2'd1,
    CFG_GRAVITY_STEP   = 2'd2,
    CFG_VELOCITY_LIMIT = 2'd3
  } cfg_idx_t;

  // per-cell control carried alongside the divider
  typedef struct packed {
    logic                          mass_nz;
    logic [Lanes-1:0]              neg;
    logic [Lanes-1:0]              ovf;
    logic [Lanes-1:0]              near_lo;
    logic [Lanes-1:0]              near_hi;
    logic [Lanes-1:0][MagW-1:0]    mom;
  } mgv_side_t;

endpackage

FILE: sv/mgv_pre.sv
// ----------------------------------------------------------------------------
// mgv_pre: input stage
// momentum magnitudes, divide overflow check and wall proximity flags
// ----------------------------------------------------------------------------
module mgv_pre (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         adv,
  input  logic                                         in_valid,
  input  logic [9:0]                                   in_cell_x,
  input  logic [9:0]                                   in_cell_y,
  input  logic [9:0]                                   in_cell_z,
  input  logic [30:0]                                  in_cell_mass,
  input  logic signed [31:0]                           in_mom_x,
  input  logic signed [31:0]                           in_mom_y,
  input  logic signed [31:0]                           in_mom_z,
  input  logic [9:0]                                   grid_res,
  input  logic [3:0]                                   boundary_width,
  output logic                                         pre_valid,
  output logic [mgv_pkg::MassW-1:0]                    pre_mass,
  output logic [mgv_pkg::Lanes-1:0][mgv_pkg::MassW-1:0] pre_rem,
  output logic [mgv_pkg::Lanes-1:0][mgv_pkg::QuoW-1:0]  pre_bits,
  output mgv_pkg::mgv_side_t                           pre_side
);
  import mgv_pkg::*;

  logic                              valid_r;
  logic [MassW-1:0]                  mass_r, mass_nxt;
  logic [Lanes-1:0][MassW-1:0]       rem_r, rem_nxt;
  logic [Lanes-1:0][QuoW-1:0]        bits_r, bits_nxt;
  mgv_side_t                         side_r, side_nxt;

  logic [Lanes-1:0][9:0]             coord;
  logic [Lanes-1:0][MagW-1:0]        mom;
  logic signed [11:0]                far_wall;

  assign coord = {in_cell_z, in_cell_y, in_cell_x};
  assign mom   = {in_mom_z, in_mom_y, in_mom_x};
  // far wall position, may go negative
  assign far_wall = $signed({2'b00, grid_res}) - $signed({8'b0, boundary_width});

  always_comb begin
    logic [MagW-1:0] mag;
    mass_nxt         = in_cell_mass;
    side_nxt.mass_nz = (in_cell_mass != '0);
    side_nxt.mom     = mom;
    for (int l = 0; l < Lanes; l++) begin
      side_nxt.neg[l] = mom[l][MagW-1];
      mag = mom[l][MagW-1] ? (~mom[l] + 32'd1) : mom[l];
      // high magnitude bits start the remainder; the rest feed the divider
      rem_nxt[l]  = {{(MassW-(MagW-OvfShift)){1'b0}}, mag[MagW-1:OvfShift]};
      bits_nxt[l] = {mag[OvfShift-1:0], {FracW{1'b0}}};
      // quotient would reach 2^QuoW
      side_nxt.ovf[l]     = (rem_nxt[l] >= in_cell_mass);
      side_nxt.near_lo[l] = (coord[l] < {6'b0, boundary_width});
      side_nxt.near_hi[l] = ($signed({2'b00, coord[l]}) >= far_wall);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mass_r <= mass_nxt;
      rem_r  <= rem_nxt;
      bits_r <= bits_nxt;
      side_r <= side_nxt;
    end
  end

  assign pre_valid = valid_r;
  assign pre_mass  = mass_r;
  assign pre_rem   = rem_r;
  assign pre_bits  = bits_r;
  assign pre_side  = side_r;

endmodule

FILE: sv/mgv_div.sv
// ----------------------------------------------------------------------------
// mgv_div: pipelined restoring divider, three lanes sharing one divisor
// one quotient bit per stage, sideband travels with each cell
// ----------------------------------------------------------------------------
module mgv_div (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          adv,
  input  logic                                          in_valid,
  input  logic [mgv_pkg::MassW-1:0]                     in_mass,
  input  logic [mgv_pkg::Lanes-1:0][mgv_pkg::MassW-1:0] in_rem,
  input  logic [mgv_pkg::Lanes-1:0][mgv_pkg::QuoW-1:0]  in_bits,
  input  mgv_pkg::mgv_side_t                            in_side,
  output logic                                          out_valid,
  output logic [mgv_pkg::Lanes-1:0][mgv_pkg::QuoW-1:0]  out_quo,
  output mgv_pkg::mgv_side_t                            out_side
);
  import mgv_pkg::*;

  logic [DivStages-1:0]             vld_r, vld_nxt;
  logic [MassW-1:0]                 mass_r [DivStages];
  logic [MassW-1:0]                 mass_nxt [DivStages];
  logic [Lanes-1:0][MassW-1:0]      rem_r [DivStages];
  logic [Lanes-1:0][MassW-1:0]      rem_nxt [DivStages];
  logic [Lanes-1:0][QuoW-1:0]       sh_r [DivStages];
  logic [Lanes-1:0][QuoW-1:0]       sh_nxt [DivStages];
  mgv_side_t                        side_r [DivStages];
  mgv_side_t                        side_nxt [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic                         vi;
    logic [MassW-1:0]             mi;
    logic [Lanes-1:0][MassW-1:0]  ri;
    logic [Lanes-1:0][QuoW-1:0]   si;
    mgv_side_t                    di;

    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign mi = in_mass;
      assign ri = in_rem;
      assign si = in_bits;
      assign di = in_side;
    end else begin : g_next
      assign vi = vld_r[k-1];
      assign mi = mass_r[k-1];
      assign ri = rem_r[k-1];
      assign si = sh_r[k-1];
      assign di = side_r[k-1];
    end

    assign vld_nxt[k]  = vi;
    assign mass_nxt[k] = mi;
    assign side_nxt[k] = di;

    always_comb begin
      logic [MassW:0] trial;
      logic [MassW:0] diff;
      logic           qbit;
      for (int l = 0; l < Lanes; l++) begin
        // bring down the next dividend bit
        trial = {ri[l], si[l][QuoW-1]};
        diff  = trial - {1'b0, mi};
        qbit  = (trial >= {1'b0, mi});
        rem_nxt[k][l] = qbit ? diff[MassW-1:0] : trial[MassW-1:0];
        // dividend bits leave at the top, quotient bits enter at the bottom
        sh_nxt[k][l]  = {si[l][QuoW-2:0], qbit};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DivStages; k++) begin
        mass_r[k] <= mass_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        sh_r[k]   <= sh_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign out_valid = vld_r[DivStages-1];
  assign out_quo   = sh_r[DivStages-1];
  assign out_side  = side_r[DivStages-1];

endmodule

FILE: sv/mgv_post.sv
// ----------------------------------------------------------------------------
// mgv_post: sign, gravity, clamp and wall rule
// two stages, the second is the output register
// ----------------------------------------------------------------------------
module mgv_post (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          adv,
  input  logic                                          in_valid,
  input  logic [mgv_pkg::Lanes-1:0][mgv_pkg::QuoW-1:0]  in_quo,
  input  mgv_pkg::mgv_side_t                            in_side,
  input  logic signed [31:0]                            gravity_step,
  input  logic [30:0]                                   velocity_limit,
  output logic                                          out_valid,
  output logic [mgv_pkg::Lanes-1:0][31:0]               out_vel
);
  import mgv_pkg::*;

  localparam int unsigned SumW = QuoW + 3;

  logic                               v1_r;
  logic [Lanes-1:0][SumW-1:0]         sum_r, sum_nxt;
  mgv_side_t                          side_r;
  logic                               v2_r;
  logic [Lanes-1:0][31:0]             vel_r, vel_nxt;

  // quotient with sign, gravity on y
  always_comb begin
    logic [QuoW:0]          qm;
    logic signed [QuoW+1:0] sq;
    logic signed [SumW-1:0] g;
    for (int l = 0; l < Lanes; l++) begin
      qm = in_side.ovf[l] ? {1'b1, {QuoW{1'b0}}} : {1'b0, in_quo[l]};
      sq = in_side.neg[l] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
      g  = (l == 1) ? SumW'(gravity_step) : '0;
      sum_nxt[l] = SumW'(sq) + g;
    end
  end

  // clamp, massless pass-through, wall rule
  always_comb begin
    logic signed [SumW-1:0] lim;
    logic signed [SumW-1:0] v;
    lim = $signed({{(SumW-31){1'b0}}, velocity_limit});
    for (int l = 0; l < Lanes; l++) begin
      if (side_r.mass_nz) begin
        v = $signed(sum_r[l]);
        if (v > lim) begin
          v = lim;
        end else if (v < -lim) begin
          v = -lim;
        end
      end else begin
        v = SumW'($signed(side_r.mom[l]));
      end
      if (side_r.near_lo[l] && v < 0) begin
        v = '0;
      end
      if (side_r.near_hi[l] && v > 0) begin
        v = '0;
      end
      vel_nxt[l] = v[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r  <= sum_nxt;
      side_r <= in_side;
      vel_r  <= vel_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_vel   = vel_r;

endmodule

FILE: sv/mpm_grid_velocity_update.sv
// ----------------------------------------------------------------------------
// mpm_grid_velocity_update: grid cell velocity update of a 3d point solver
// momentum over mass, gravity, velocity clamp and wall boundary rule
// ----------------------------------------------------------------------------
// usage
//   input channel: one grid cell per transaction (coordinates, mass and
//   momentum, Q16.16), taken when in_valid is high and in_stall is low
//   output channel: one velocity triple per cell, in the same order, taken
//   when out_valid is high and out_stall is low
//   path: the cell passes one input stage, a 34 stage divider (one quotient
//   bit per stage) and two output stages, 37 registers in all
//   throughput: one cell per cycle while the receiver keeps up
//   stall: the whole pipeline freezes only while a result sits in the output
//   register and out_stall is high; in_stall mirrors that condition
//   reset: synchronous, clears all valid bits and loads the register defaults
//   configuration: write with cfg_we while no cell is in flight
// ----------------------------------------------------------------------------
module mpm_grid_velocity_update (
  input  logic               clk,
  input  logic               rst_n,
  // configuration write port
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // cell input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [9:0]         in_cell_x,
  input  logic [9:0]         in_cell_y,
  input  logic [9:0]         in_cell_z,
  input  logic [30:0]        in_cell_mass,
  input  logic signed [31:0] in_mom_x,
  input  logic signed [31:0] in_mom_y,
  input  logic signed [31:0] in_mom_z,
  // velocity output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_vel_z
);
  import mgv_pkg::*;

  // configuration registers
  logic [9:0]         grid_res_r;
  logic [3:0]         boundary_width_r;
  logic signed [31:0] gravity_step_r;
  logic [30:0]        velocity_limit_r;

  // pipeline advance: output register empty or being drained
  logic adv;

  logic                         pre_valid;
  logic [MassW-1:0]             pre_mass;
  logic [Lanes-1:0][MassW-1:0]  pre_rem;
  logic [Lanes-1:0][QuoW-1:0]   pre_bits;
  mgv_side_t                    pre_side;

  logic                         div_valid;
  logic [Lanes-1:0][QuoW-1:0]   div_quo;
  mgv_side_t                    div_side;

  logic [Lanes-1:0][31:0]       vel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_res_r       <= 10'd64;
      boundary_width_r <= 4'd3;
      gravity_step_r   <= '0;
      velocity_limit_r <= 31'd655360;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GRID_RES:       grid_res_r       <= cfg_data[9:0];
        CFG_BOUNDARY_WIDTH: boundary_width_r <= cfg_data[3:0];
        CFG_GRAVITY_STEP:   gravity_step_r   <= $signed(cfg_data);
        CFG_VELOCITY_LIMIT: velocity_limit_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // a held result stops every stage, bubbles included
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // magnitudes, overflow check, wall flags
  mgv_pre u_pre (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_valid       (in_valid),
    .in_cell_x      (in_cell_x),
    .in_cell_y      (in_cell_y),
    .in_cell_z      (in_cell_z),
    .in_cell_mass   (in_cell_mass),
    .in_mom_x       (in_mom_x),
    .in_mom_y       (in_mom_y),
    .in_mom_z       (in_mom_z),
    .grid_res       (grid_res_r),
    .boundary_width (boundary_width_r),
    .pre_valid      (pre_valid),
    .pre_mass       (pre_mass),
    .pre_rem        (pre_rem),
    .pre_bits       (pre_bits),
    .pre_side       (pre_side)
  );

  // momentum magnitude times 2^16 over mass, all three lanes in step
  mgv_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (pre_valid),
    .in_mass   (pre_mass),
    .in_rem    (pre_rem),
    .in_bits   (pre_bits),
    .in_side   (pre_side),
    .out_valid (div_valid),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // sign, gravity, clamp, walls and the output register
  mgv_post u_post (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_valid       (div_valid),
    .in_quo         (div_quo),
    .in_side        (div_side),
    .gravity_step   (gravity_step_r),
    .velocity_limit (velocity_limit_r),
    .out_valid      (out_valid),
    .out_vel        (vel)
  );

  assign out_vel_x = $signed(vel[0]);
  assign out_vel_y = $signed(vel[1]);
  assign out_vel_z = $signed(vel[2]);

endmodule

FILE: sv/mgv_checker.sv
// ----------------------------------------------------------------------------
// mgv_checker: port level checks of the grid velocity update
// bound to the top level
// ----------------------------------------------------------------------------
module mgv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_vel_x,
  input logic [31:0] out_vel_y,
  input logic [31:0] out_vel_z
);

  // input backpressure comes only from a held result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow the output register");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // a stalled result stays
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // a stalled result does not change
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      $stable(out_vel_x) && $stable(out_vel_y) && $stable(out_vel_z))
    else $error("stalled result changed");

endmodule

bind mpm_grid_velocity_update mgv_checker u_mgv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_vel_x (out_vel_x),
  .out_vel_y (out_vel_y),
  .out_vel_z (out_vel_z)
);
